FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the TLV header parser.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DTP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("dtp property failed");

// Condition must never be seen at a clock edge outside reset.
`define DTP_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("dtp forbidden condition seen");

`endif

FILE: hw/rtl/dtp_pkg.sv
// Package of the DER TLV header parser: widths, codes, phase type and the
// structs passed between front end, queue and parser. No dependencies.
package dtp_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 32;
	localparam int KIND_W   = 2;
	localparam int ERR_W    = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// Defaults for the top-level parameters
	localparam int MAX_LENGTH_OCTETS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF       = 2;

	// Identifier and length octet constants
	localparam logic [BYTE_W-1:0] TAG_NUM_MASK  = 8'h1f;
	localparam logic [BYTE_W-1:0] LEN_LONG_FORM = 8'h80;
	localparam logic [LEN_W-1:0]  LEN_MIN_LONG  = 32'h0000_0080;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_TAG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TAG_CHECK    = 1'b1;

	// Event kinds
	localparam logic [KIND_W-1:0] EV_HDR_BYTE = 2'd0;
	localparam logic [KIND_W-1:0] EV_HDR_DONE = 2'd1;
	localparam logic [KIND_W-1:0] EV_VALUE    = 2'd2;
	localparam logic [KIND_W-1:0] EV_HALT     = 2'd3;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE      = 4'd0;
	localparam logic [ERR_W-1:0] ERR_HIGH_TAG  = 4'd1;
	localparam logic [ERR_W-1:0] ERR_SHORT     = 4'd2;
	localparam logic [ERR_W-1:0] ERR_INDEF     = 4'd3;
	localparam logic [ERR_W-1:0] ERR_TOO_MANY  = 4'd4;
	localparam logic [ERR_W-1:0] ERR_LEAD_ZERO = 4'd5;
	localparam logic [ERR_W-1:0] ERR_NON_MIN   = 4'd6;
	localparam logic [ERR_W-1:0] ERR_OVERRUN   = 4'd7;
	localparam logic [ERR_W-1:0] ERR_MISMATCH  = 4'd8;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LEN1,
		PH_LENX,
		PH_VALUE,
		PH_HALT
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] expected_tag;
		logic              tag_check_enable;
	} cfg_t;

	// Classified input byte as held in the queue
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              window_start;
		logic [LEN_W-1:0]  window_length;
		logic              empty_window;
		logic              high_tag;
		logic              short_len;
		logic              indef_len;
		logic              too_many;
		logic              zero_byte;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [BYTE_W-1:0] element_tag;
		logic [LEN_W-1:0]  value_length;
		logic [BYTE_W-1:0] value_byte;
		logic              value_last;
		logic [ERR_W-1:0]  error_code;
		logic              window_done;
	} result_t;

endpackage

FILE: hw/rtl/dtp_if.sv
// Valid/ready channel interfaces of the DER TLV header parser.
// Depends on dtp_pkg for field widths.
interface dtp_in_if;
	import dtp_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              window_start;
	logic [LEN_W-1:0]  window_length;

	modport source(output valid, data_byte, window_start, window_length, input ready);
	modport sink(input valid, data_byte, window_start, window_length, output ready);
endinterface

interface dtp_out_if;
	import dtp_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] event_kind;
	logic [BYTE_W-1:0] element_tag;
	logic [LEN_W-1:0]  value_length;
	logic [BYTE_W-1:0] value_byte;
	logic              value_last;
	logic [ERR_W-1:0]  error_code;
	logic              window_done;

	modport source(output valid, event_kind, element_tag, value_length, value_byte,
		value_last, error_code, window_done, input ready);
	modport sink(input valid, event_kind, element_tag, value_length, value_byte,
		value_last, error_code, window_done, output ready);
endinterface

FILE: hw/rtl/dtp_front.sv
// Front end: takes input transfers and classifies each byte for the parser.
// Depends on dtp_pkg and dtp_in_if.
module dtp_front #(
	parameter int MAX_LENGTH_OCTETS = dtp_pkg::MAX_LENGTH_OCTETS_DEF
) (
	dtp_in_if.sink         in_ch,
	output logic           push_valid,
	output dtp_pkg::item_t push_item,
	input  logic           push_ready
);
	import dtp_pkg::*;

	// Pass the handshake through to the queue
	assign push_valid  = in_ch.valid;
	assign in_ch.ready = push_ready;

	// Precompute the byte classes the parser tests
	always_comb begin
		push_item.data_byte     = in_ch.data_byte;
		push_item.window_start  = in_ch.window_start;
		push_item.window_length = in_ch.window_length;
		push_item.empty_window  = (in_ch.window_length == '0);
		push_item.high_tag      = ((in_ch.data_byte & TAG_NUM_MASK) == TAG_NUM_MASK);
		push_item.short_len     = (in_ch.data_byte < LEN_LONG_FORM);
		push_item.indef_len     = (in_ch.data_byte == LEN_LONG_FORM);
		push_item.too_many      = (in_ch.data_byte[6:0] > 7'(MAX_LENGTH_OCTETS));
		push_item.zero_byte     = (in_ch.data_byte == '0);
	end

endmodule

FILE: hw/rtl/dtp_queue.sv
// Short queue of classified bytes between front end and parser.
// Depends on dtp_pkg for the entry type.
module dtp_queue #(
	parameter int DEPTH = dtp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  dtp_pkg::item_t push_item,
	output logic           push_ready,
	output logic           pop_valid,
	output dtp_pkg::item_t pop_item,
	input  logic           pop_ready
);
	import dtp_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/dtp_back.sv
// Parser back end: TLV state machine, one byte per cycle unless out_ch
// stalls; results go to an output register. Uses dtp_pkg and dtp_out_if.
module dtp_back #(
	parameter int MAX_LENGTH_OCTETS = dtp_pkg::MAX_LENGTH_OCTETS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  dtp_pkg::cfg_t  cfg,
	input  logic           pop_valid,
	input  dtp_pkg::item_t pop_item,
	output logic           pop_ready,
	dtp_out_if.source      out_ch
);
	import dtp_pkg::*;

	localparam int CNT_W = $clog2(MAX_LENGTH_OCTETS + 1);

	// Parser state
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] held_tag_q, held_tag_d;
	logic [LEN_W-1:0]  acc_q, acc_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [LEN_W-1:0]  window_left_q, window_left_d;
	logic [LEN_W-1:0]  vleft_q, vleft_d;
	logic [ERR_W-1:0]  sticky_q, sticky_d;

	// Output register
	logic    out_valid_q;
	result_t res_q, res_d;

	// Per-byte decode
	logic              take;
	logic [BYTE_W-1:0] b;
	phase_t            phase_eff;
	logic [LEN_W-1:0]  win_eff;
	logic [ERR_W-1:0]  sticky_eff;
	logic [LEN_W-1:0]  acc_eff;
	logic [CNT_W-1:0]  cnt_eff;
	logic [LEN_W-1:0]  vleft_eff;
	logic              active;
	logic              halted;
	logic [LEN_W-1:0]  rest;
	logic [LEN_W-1:0]  acc_sh;
	logic [CNT_W-1:0]  cnt_dec;
	logic [LEN_W-1:0]  vdec;
	logic [LEN_W-1:0]  fin_len;
	logic [ERR_W-1:0]  fin_err;
	logic [ERR_W-1:0]  err_new;
	logic              hdr_done;
	logic              len1_long_ok;
	logic              lenx_shift;
	logic              value_step;

	assign pop_ready = !out_valid_q || out_ch.ready;
	assign take      = pop_valid && pop_ready;
	assign b         = pop_item.data_byte;

	// Apply a window start ahead of the byte itself
	always_comb begin
		if (pop_item.window_start) begin
			win_eff    = pop_item.window_length;
			phase_eff  = pop_item.empty_window ? PH_HALT : PH_TAG;
			sticky_eff = pop_item.empty_window ? ERR_SHORT : ERR_NONE;
			acc_eff    = '0;
			cnt_eff    = '0;
			vleft_eff  = '0;
		end else begin
			win_eff    = window_left_q;
			phase_eff  = phase_q;
			sticky_eff = sticky_q;
			acc_eff    = acc_q;
			cnt_eff    = cnt_q;
			vleft_eff  = vleft_q;
		end
	end

	// Shared arithmetic: window countdown, length shift-in, header checks
	always_comb begin
		active  = (win_eff != '0);
		halted  = !active || (phase_eff == PH_HALT);
		rest    = win_eff - 1'b1;
		acc_sh  = {acc_eff[LEN_W-BYTE_W-1:0], b};
		cnt_dec = (cnt_eff != '0) ? cnt_eff - 1'b1 : '0;
		vdec    = (vleft_eff != '0) ? vleft_eff - 1'b1 : '0;
		fin_len = (phase_eff == PH_LEN1) ? LEN_W'(b) : acc_sh;
		if (fin_len > rest) begin
			fin_err = ERR_OVERRUN;
		end else if (cfg.tag_check_enable && (held_tag_q != cfg.expected_tag)) begin
			fin_err = ERR_MISMATCH;
		end else begin
			fin_err = ERR_NONE;
		end
	end

	// Decode the byte against the current phase
	always_comb begin
		err_new      = ERR_NONE;
		hdr_done     = 1'b0;
		len1_long_ok = 1'b0;
		lenx_shift   = 1'b0;
		value_step   = 1'b0;
		if (active) begin
			unique case (phase_eff)
				PH_TAG: begin
					if (pop_item.high_tag) begin
						err_new = ERR_HIGH_TAG;
					end else if (rest == '0) begin
						err_new = ERR_SHORT;
					end
				end
				PH_LEN1: begin
					if (pop_item.short_len) begin
						err_new  = fin_err;
						hdr_done = (fin_err == ERR_NONE);
					end else if (pop_item.indef_len) begin
						err_new = ERR_INDEF;
					end else if (pop_item.too_many) begin
						err_new = ERR_TOO_MANY;
					end else if (rest < LEN_W'(b[6:0])) begin
						err_new = ERR_SHORT;
					end else begin
						len1_long_ok = 1'b1;
					end
				end
				PH_LENX: begin
					if ((acc_eff == '0) && pop_item.zero_byte) begin
						err_new = ERR_LEAD_ZERO;
					end else if (acc_eff[LEN_W-1:LEN_W-BYTE_W] != '0) begin
						err_new = ERR_OVERRUN;
					end else begin
						lenx_shift = 1'b1;
						if (cnt_dec == '0) begin
							if (acc_sh < LEN_MIN_LONG) begin
								err_new = ERR_NON_MIN;
							end else begin
								err_new  = fin_err;
								hdr_done = (fin_err == ERR_NONE);
							end
						end
					end
				end
				PH_VALUE: begin
					value_step = 1'b1;
				end
				PH_HALT: begin
					err_new = ERR_NONE;
				end
				default: begin
					err_new = ERR_NONE;
				end
			endcase
		end
	end

	// Next state
	always_comb begin
		window_left_d = active ? rest : '0;
		sticky_d      = (err_new != ERR_NONE) ? err_new : sticky_eff;
		held_tag_d    = (active && (phase_eff == PH_TAG)) ? b : held_tag_q;
		acc_d         = acc_eff;
		cnt_d         = cnt_eff;
		vleft_d       = vleft_eff;
		phase_d       = phase_eff;
		if (len1_long_ok) begin
			acc_d = '0;
			cnt_d = b[CNT_W-1:0];
		end
		if (lenx_shift) begin
			acc_d = acc_sh;
			cnt_d = cnt_dec;
		end
		if (value_step) begin
			vleft_d = vdec;
		end
		if (hdr_done && (fin_len != '0)) begin
			vleft_d = fin_len;
		end
		if (err_new != ERR_NONE) begin
			phase_d = PH_HALT;
		end else if (hdr_done) begin
			phase_d = (fin_len == '0) ? PH_TAG : PH_VALUE;
		end else if (active) begin
			unique case (phase_eff)
				PH_TAG:   phase_d = PH_LEN1;
				PH_LEN1:  phase_d = PH_LENX;
				PH_LENX:  phase_d = PH_LENX;
				PH_VALUE: phase_d = (vdec == '0) ? PH_TAG : PH_VALUE;
				PH_HALT:  phase_d = PH_HALT;
				default:  phase_d = PH_HALT;
			endcase
		end
	end

	// Result fields
	always_comb begin
		if ((err_new != ERR_NONE) || halted) begin
			res_d.event_kind = EV_HALT;
		end else if (hdr_done) begin
			res_d.event_kind = EV_HDR_DONE;
		end else if (value_step) begin
			res_d.event_kind = EV_VALUE;
		end else begin
			res_d.event_kind = EV_HDR_BYTE;
		end
		if (err_new != ERR_NONE) begin
			res_d.error_code = err_new;
		end else begin
			res_d.error_code = halted ? sticky_eff : ERR_NONE;
		end
		res_d.element_tag  = held_tag_d;
		res_d.value_length = hdr_done ? fin_len : '0;
		res_d.value_byte   = value_step ? b : '0;
		res_d.value_last   = (hdr_done && (fin_len == '0)) || (value_step && (vdec == '0));
		res_d.window_done  = active && (rest == '0);
	end

	// Hold parser state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_TAG;
			held_tag_q    <= '0;
			acc_q         <= '0;
			cnt_q         <= '0;
			window_left_q <= '0;
			vleft_q       <= '0;
			sticky_q      <= ERR_NONE;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				phase_q       <= phase_d;
				held_tag_q    <= held_tag_d;
				acc_q         <= acc_d;
				cnt_q         <= cnt_d;
				window_left_q <= window_left_d;
				vleft_q       <= vleft_d;
				sticky_q      <= sticky_d;
				out_valid_q   <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.event_kind   = res_q.event_kind;
	assign out_ch.element_tag  = res_q.element_tag;
	assign out_ch.value_length = res_q.value_length;
	assign out_ch.value_byte   = res_q.value_byte;
	assign out_ch.value_last   = res_q.value_last;
	assign out_ch.error_code   = res_q.error_code;
	assign out_ch.window_done  = res_q.window_done;

endmodule

FILE: hw/rtl/der_tlv_header_parser_top.sv
// DER TLV header parser. Byte-serial reader of tag-length-value elements in a window.
//
// Channels: in_ch carries one byte per transfer with window_start and window_length;
// the first byte of a window arrives with window_start high. out_ch gives one
// result per input byte: event kind, element tag, decoded length on header complete,
// passed-through value byte with a last mark, error code and end-of-window flag.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 expected tag,
// 1 tag check enable) at a clock edge; write only while no byte is in flight.
// Throughput: one byte per cycle while out_ch takes results; a parser step does the
// window countdown, length shift-in and 32-bit compares with the window remainder.
// Path: a transferred byte is first written into the queue, and the parser step then
// loads its result into the output register.
// Stall: a stalled out_ch holds its result; the queue (QUEUE_DEPTH entries) fills and
// then in_ch.ready drops until out_ch takes a result.
// Reset: arst_n clears parser state, queue and configuration; no window is open
// until a byte with window_start arrives, and bytes before that report a halt.
// Depends on dtp_pkg, dtp_if, dtp_front, dtp_queue and dtp_back.
module der_tlv_header_parser_top #(
	parameter int MAX_LENGTH_OCTETS = dtp_pkg::MAX_LENGTH_OCTETS_DEF,
	parameter int QUEUE_DEPTH       = dtp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	dtp_in_if.sink                           in_ch,
	dtp_out_if.source                        out_ch,
	input  logic                             cfg_we,
	input  logic [dtp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dtp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import dtp_pkg::*;

	cfg_t  cfg_q;
	logic  push_valid;
	item_t push_item;
	logic  push_ready;
	logic  pop_valid;
	item_t pop_item;
	logic  pop_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_tag     <= '0;
			cfg_q.tag_check_enable <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPECTED_TAG: cfg_q.expected_tag     <= cfg_wdata;
				REG_TAG_CHECK:    cfg_q.tag_check_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	dtp_front #(
		.MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS)
	) u_front (
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	dtp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	dtp_back #(
		.MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready),
		.out_ch    (out_ch)
	);

endmodule

FILE: hw/rtl/dtp_checker.sv
// Port-level checks on the result channel of the TLV header parser, bound
// to the top level. Depends on dtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dtp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [dtp_pkg::KIND_W-1:0] out_event_kind,
	input logic [dtp_pkg::LEN_W-1:0]  out_value_length,
	input logic                       out_value_last,
	input logic [dtp_pkg::ERR_W-1:0]  out_error_code
);
	import dtp_pkg::*;

	// A stalled result stays offered
	`DTP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

	// Errors are reported only with the halt event
	`DTP_NEVER(a_err_on_halt, out_valid && (out_error_code != ERR_NONE) && (out_event_kind != EV_HALT))

	// A completed header is last exactly when its value is empty
	`DTP_ASSERT(a_hdr_last, out_valid && (out_event_kind == EV_HDR_DONE) |-> (out_value_last == (out_value_length == '0)))

	// Lengths appear only on header complete
	`DTP_NEVER(a_len_on_hdr, out_valid && (out_event_kind != EV_HDR_DONE) && (out_value_length != '0))

endmodule

bind der_tlv_header_parser_top dtp_checker u_dtp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_event_kind   (out_ch.event_kind),
	.out_value_length (out_ch.value_length),
	.out_value_last   (out_ch.value_last),
	.out_error_code   (out_ch.error_code)
);

FILE: sim/dtp_checker.sv
// Scoreboard for the DER TLV header parser. It decodes every transferred input byte beside
// the block and compares the result stream in order.
// Depends on dtp_pkg and the channel interfaces of dtp_if.
module dtp_scoreboard #(
	parameter int MAX_LENGTH_OCTETS = dtp_pkg::MAX_LENGTH_OCTETS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	dtp_in_if                                in_mon,
	dtp_out_if                               out_mon,
	input  logic                             cfg_we,
	input  logic [dtp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dtp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output int                               mismatches,
	output int                               outstanding,
	output int                               results_checked,
	output int                               error_reports
);
	timeunit 1ns;
	timeprecision 1ps;
	import dtp_pkg::*;

	localparam logic [BYTE_W-1:0] LEN_COUNT_MASK = 8'h7f;

	// Shadow registers and parser state
	logic [BYTE_W-1:0] shadow_tag;
	logic              check_on;
	phase_t            phase;
	logic [BYTE_W-1:0] cur_tag;
	logic [LEN_W-1:0]  len_acc;
	logic [3:0]        octets_left;
	logic [LEN_W-1:0]  window_left;
	logic [LEN_W-1:0]  value_left;
	logic [ERR_W-1:0]  held_error;

	result_t pending_events[$];
	int      fail_count;
	int      compared;
	int      err_seen;

	// Stop parsing until the next window opens
	function automatic result_t halt_parse(input logic [ERR_W-1:0] code, input result_t r);
		held_error = code;
		phase = PH_HALT;
		r.event_kind = EV_HALT;
		r.error_code = code;
		return r;
	endfunction

	// Close a header: window room first, then the tag compare
	function automatic result_t end_header(input logic [LEN_W-1:0] len,
		input logic [LEN_W-1:0] rest, input result_t r);
		if (len > rest)
			return halt_parse(ERR_OVERRUN, r);
		if (check_on && cur_tag != shadow_tag)
			return halt_parse(ERR_MISMATCH, r);
		r.event_kind = EV_HDR_DONE;
		r.value_length = len;
		if (len == '0) begin
			r.value_last = 1'b1;
			phase = PH_TAG;
		end else begin
			value_left = len;
			phase = PH_VALUE;
		end
		return r;
	endfunction

	// Advance the parser by one byte and return the event it should report
	function automatic result_t decode_byte(input logic [BYTE_W-1:0] b, input logic ws,
		input logic [LEN_W-1:0] wl);
		result_t           r;
		logic [LEN_W-1:0]  rest;
		logic [BYTE_W-1:0] count;
		r = '0;
		if (ws) begin
			held_error = ERR_NONE;
			phase = PH_TAG;
			window_left = wl;
			value_left = '0;
			octets_left = '0;
			len_acc = '0;
			if (wl == '0)
				r = halt_parse(ERR_SHORT, r);
		end
		if (window_left == '0) begin
			// nothing open: byte is not consumed
			r.event_kind = EV_HALT;
			r.error_code = held_error;
		end else begin
			window_left = window_left - 1;
			rest = window_left;
			r.window_done = (rest == '0);
			case (phase)
				PH_TAG: begin
					cur_tag = b;
					if ((b & TAG_NUM_MASK) == TAG_NUM_MASK)
						r = halt_parse(ERR_HIGH_TAG, r);
					else if (rest == '0)
						r = halt_parse(ERR_SHORT, r);
					else
						phase = PH_LEN1;
				end
				PH_LEN1: begin
					if (b < LEN_LONG_FORM) begin
						r = end_header(LEN_W'(b), rest, r);
					end else if (b == LEN_LONG_FORM) begin
						r = halt_parse(ERR_INDEF, r);
					end else begin
						count = b & LEN_COUNT_MASK;
						if (count > MAX_LENGTH_OCTETS)
							r = halt_parse(ERR_TOO_MANY, r);
						else if (rest < LEN_W'(count))
							r = halt_parse(ERR_SHORT, r);
						else begin
							octets_left = count[3:0];
							len_acc = '0;
							phase = PH_LENX;
						end
					end
				end
				PH_LENX: begin
					if (len_acc == '0 && b == '0) begin
						r = halt_parse(ERR_LEAD_ZERO, r);
					end else if (len_acc[31:24] != '0) begin
						r = halt_parse(ERR_OVERRUN, r);
					end else begin
						len_acc = {len_acc[23:0], b};
						if (octets_left != '0)
							octets_left = octets_left - 1'b1;
						if (octets_left == '0) begin
							if (len_acc < LEN_MIN_LONG)
								r = halt_parse(ERR_NON_MIN, r);
							else
								r = end_header(len_acc, rest, r);
						end
					end
				end
				PH_VALUE: begin
					r.event_kind = EV_VALUE;
					r.value_byte = b;
					if (value_left != '0)
						value_left = value_left - 1;
					if (value_left == '0) begin
						r.value_last = 1'b1;
						phase = PH_TAG;
					end
				end
				default: begin
					r.event_kind = EV_HALT;
					r.error_code = held_error;
				end
			endcase
		end
		r.element_tag = cur_tag;
		return r;
	endfunction

	// Compare results first, then queue the prediction for the byte taken at this edge
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			shadow_tag = '0;
			check_on = 1'b0;
			phase = PH_TAG;
			cur_tag = '0;
			len_acc = '0;
			octets_left = '0;
			window_left = '0;
			value_left = '0;
			held_error = ERR_NONE;
			pending_events.delete();
			fail_count = 0;
			compared = 0;
			err_seen = 0;
			mismatches <= 0;
			outstanding <= 0;
			results_checked <= 0;
			error_reports <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_EXPECTED_TAG: shadow_tag = cfg_wdata;
					REG_TAG_CHECK:    check_on = cfg_wdata[0];
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				got.event_kind   = out_mon.event_kind;
				got.element_tag  = out_mon.element_tag;
				got.value_length = out_mon.value_length;
				got.value_byte   = out_mon.value_byte;
				got.value_last   = out_mon.value_last;
				got.error_code   = out_mon.error_code;
				got.window_done  = out_mon.window_done;
				if (pending_events.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with nothing pending: kind %0d tag %0h err %0d",
							$realtime, got.event_kind, got.element_tag, got.error_code);
				end else begin
					want = pending_events.pop_front();
					compared++;
					if (want.event_kind == EV_HALT && want.error_code != ERR_NONE)
						err_seen++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: result %0d differs", $realtime, compared);
							$display("  expected kind %0d tag %0h len %0d byte %0h last %0b err %0d done %0b",
								want.event_kind, want.element_tag, want.value_length,
								want.value_byte, want.value_last, want.error_code, want.window_done);
							$display("  actual   kind %0d tag %0h len %0d byte %0h last %0b err %0d done %0b",
								got.event_kind, got.element_tag, got.value_length,
								got.value_byte, got.value_last, got.error_code, got.window_done);
						end
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				pending_events.push_back(decode_byte(in_mon.data_byte, in_mon.window_start,
					in_mon.window_length));
			mismatches <= fail_count;
			outstanding <= pending_events.size();
			results_checked <= compared;
			error_reports <= err_seen;
		end
	end

endmodule

FILE: sim/testbench.sv
// Top of the DER TLV header parser bench: clock, reset, byte stimulus, register writes
// and receiver stalls. Checking lives in dtp_scoreboard; depends on dtp_pkg and dtp_if.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dtp_pkg::*;

	localparam int PERIOD       = 8;
	localparam int HOLD_CYCLES  = 80;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_BYTES = 1450;
	localparam int PHASES       = 6;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int mismatches;
	int outstanding;
	int results_checked;
	int error_reports;

	logic [BYTE_W-1:0] frame[$];
	logic [BYTE_W-1:0] tag_setting;
	logic              check_setting;
	bit                calm;
	bit                hold_req;
	int                bytes_sent;
	int                windows_sent;
	int                settings_used;
	int                cycle_count;

	dtp_in_if  in_ch();
	dtp_out_if out_ch();

	der_tlv_header_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	dtp_scoreboard scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_mon          (in_ch),
		.out_mon         (out_ch),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.error_reports   (error_reports)
	);

	always #(PERIOD/2) clk = ~clk;

	// Idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one byte, hold it until the transfer
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic ws,
		input logic [LEN_W-1:0] wl);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.window_start <= ws;
		in_ch.window_length <= wl;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	// Drop valid and wait until every result has come back
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	// Write both registers; only called with the block idle
	task automatic set_regs(input logic [BYTE_W-1:0] tag, input logic en);
		cfg_we <= 1'b1;
		cfg_index <= REG_EXPECTED_TAG;
		cfg_wdata <= tag;
		@(posedge clk);
		cfg_index <= REG_TAG_CHECK;
		cfg_wdata <= {7'($urandom()), en};
		@(posedge clk);
		cfg_we <= 1'b0;
		tag_setting = tag;
		check_setting = en;
		settings_used++;
	endtask

	// Open a window of length wl over the bytes in frame
	task automatic send_frame(input logic [LEN_W-1:0] wl);
		windows_sent++;
		foreach (frame[i])
			send_byte(frame[i], i == 0, (i == 0) ? wl : LEN_W'($urandom()));
	endtask

	function automatic logic [BYTE_W-1:0] pick_tag();
		int                r;
		logic [BYTE_W-1:0] t;
		r = $urandom_range(0, 99);
		if (check_setting && r < 75)
			return tag_setting;
		if (r < 85)
			return {3'($urandom()), TAG_NUM_MASK[4:0]};
		t = BYTE_W'($urandom());
		if ((t & TAG_NUM_MASK) == TAG_NUM_MASK)
			t[0] = 1'b0;
		return t;
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 0;
		if (r < 85)
			return $urandom_range(1, 8);
		if (r < 97)
			return $urandom_range(9, 24);
		if (r < 99)
			return $urandom_range(128, 200);
		return $urandom_range(256, 300);
	endfunction

	// Append a well-formed element with minimal length encoding
	task automatic add_element(input logic [BYTE_W-1:0] tag, input int len);
		int k;
		frame.push_back(tag);
		if (len < 128) begin
			frame.push_back(BYTE_W'(len));
		end else begin
			k = (len < 256) ? 1 : (len < 65536) ? 2 : 3;
			frame.push_back(LEN_LONG_FORM | BYTE_W'(k));
			for (int j = k - 1; j >= 0; j--)
				frame.push_back(BYTE_W'(len >> (8 * j)));
		end
		repeat (len) frame.push_back(BYTE_W'($urandom()));
	endtask

	// Append a header with a broken length field
	task automatic add_broken(input logic [BYTE_W-1:0] tag);
		frame.push_back(tag);
		case ($urandom_range(0, 4))
			0: frame.push_back(LEN_LONG_FORM);
			1: frame.push_back(LEN_LONG_FORM | BYTE_W'($urandom_range(5, 127)));
			2: begin
				frame.push_back(LEN_LONG_FORM | 8'd1);
				frame.push_back(BYTE_W'($urandom_range(0, 127)));
			end
			3: begin
				frame.push_back(LEN_LONG_FORM | BYTE_W'($urandom_range(2, 4)));
				frame.push_back(8'h00);
				frame.push_back(BYTE_W'($urandom()));
			end
			default: begin
				// four octets of length: a length of at least 2^24
				frame.push_back(LEN_LONG_FORM | 8'd4);
				frame.push_back(BYTE_W'($urandom_range(1, 255)));
				repeat (3) frame.push_back(BYTE_W'($urandom()));
			end
		endcase
	endtask

	// Build one window of elements, sometimes damaged or with the wrong length
	task automatic random_window();
		int               size;
		int               r;
		logic [LEN_W-1:0] wl;
		frame.delete();
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 19) == 0)
				add_broken(pick_tag());
			else
				add_element(pick_tag(), pick_len());
		end
		size = frame.size();
		if ($urandom_range(0, 11) == 0)
			frame[$urandom_range(0, size - 1)] = BYTE_W'($urandom());
		r = $urandom_range(0, 99);
		if (r < 75)
			wl = size;
		else if (r < 85)
			wl = size + $urandom_range(1, 3);
		else if (r < 95 && size > 1)
			wl = $urandom_range(1, size - 1);
		else
			wl = $urandom();
		send_frame(wl);
	endtask

	// Stray bytes with random starts and lengths
	task automatic noise();
		repeat ($urandom_range(1, 6))
			send_byte(BYTE_W'($urandom()), $urandom_range(0, 3) == 0,
				$urandom_range(0, 1) ? LEN_W'($urandom()) : LEN_W'($urandom_range(0, 4)));
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		int on_left;
		int off_left;
		on_left = 0;
		off_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (off_left > 0) begin
				out_ch.ready <= 1'b0;
				off_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (on_left > 0)
					on_left--;
				else begin
					on_left = $urandom_range(0, 15);
					off_left = gap_len();
				end
			end
		end
	end

	// Run guard
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		int                phase_end;
		logic [BYTE_W-1:0] tags[PHASES];
		bit                checks[PHASES];
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= '0;
		in_ch.window_start <= 1'b0;
		in_ch.window_length <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_EXPECTED_TAG;
		cfg_wdata <= '0;
		tag_setting = '0;
		check_setting = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		bytes_sent = 0;
		windows_sent = 0;
		settings_used = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte with no window open, then an empty window
		send_byte(8'h30, 1'b0, '0);
		send_byte(8'h30, 1'b1, '0);
		// high tag number form
		frame = '{8'h1f};
		send_frame(3);
		// indefinite length, then a halted byte closing the window
		frame = '{8'h30, 8'h80, 8'hff};
		send_frame(3);
		// too many length octets
		frame = '{8'h30, 8'h85};
		send_frame(2);
		// tag as the last byte of the window
		frame = '{8'h30};
		send_frame(1);
		// long form running past the window
		frame = '{8'h30, 8'h83, 8'h01};
		send_frame(3);
		// leading zero length octet
		frame = '{8'h30, 8'h82, 8'h00};
		send_frame(4);
		// long form for a short length
		frame = '{8'h30, 8'h81, 8'h7f};
		send_frame(3);
		// value longer than the window
		frame = '{8'h04, 8'h05};
		send_frame(3);
		// two good elements, the second empty, then a byte past the window
		frame = '{8'h04, 8'h02, 8'haa, 8'h55, 8'h05, 8'h00};
		send_frame(6);
		send_byte(8'hff, 1'b0, '0);
		// tag mismatch with checking on
		drain();
		set_regs(8'h02, 1'b1);
		frame = '{8'h04, 8'h00};
		send_frame(2);

		// random phases over several register settings, extremes included
		tags = '{BYTE_W'($urandom()), 8'h00, 8'hff, BYTE_W'($urandom()), 8'hff,
			BYTE_W'($urandom())};
		checks = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_regs(tags[p], checks[p]);
			phase_end = bytes_sent + RANDOM_BYTES / PHASES;
			if (p == 1) begin
				// hold the receiver off while a long element keeps coming
				hold_req = 1'b1;
				calm = 1'b1;
				frame.delete();
				add_element(pick_tag(), 30);
				send_frame(frame.size());
			end
			calm = (p == 3);
			while (bytes_sent < phase_end) begin
				if ($urandom_range(0, 19) == 0)
					noise();
				else
					random_window();
			end
			calm = 1'b0;
		end

		drain();
		repeat (4) @(posedge clk);
		$display("Run covered %0d windows and %0d bytes under %0d register settings.",
			windows_sent, bytes_sent, settings_used);
		$display("%0d results compared in order, %0d of them error reports.",
			results_checked, error_reports);
		if (mismatches == 0 && outstanding == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
